[hdl/ille_pkg.sv]
// ----------------------------------------------------------------------------
// ille_pkg
// Shared types and codes of the indexed linked list engine: command and
// status codes, sequencer states, operation modes and free-pool controls.
// ----------------------------------------------------------------------------
`default_nettype none

package ille_pkg;

  // Fixed field widths
  localparam int VAL_W = 32;
  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int STS_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  // Status codes
  localparam logic [STS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  // Value returned when nothing is read
  localparam logic [VAL_W-1:0] NO_VALUE = '1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DEL_NEXT,
    S_ALLOC,
    S_LINK,
    S_FIN
  } state_t;

  // Operation mode of the item in flight
  typedef enum logic [2:0] {
    M_NONE,
    M_GET,
    M_HEAD,
    M_TAIL,
    M_MID,
    M_DEL0,
    M_DELM
  } mode_t;

  // Free-pool controls from the sequencer
  typedef struct packed {
    logic prefetch;
    logic pop;
    logic push;
  } pool_ctl_t;

endpackage

`default_nettype wire

[hdl/indexed_linked_list_engine.sv]
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Bounded singly linked list of signed 32-bit values in a node store, with
// head, tail and length registers and a free-slot pool.
// ----------------------------------------------------------------------------
// One item is in work at a time; the next is taken once its result sits in
// the output register. A request rejected for range or full goes straight to
// the finish state; add at head or tail passes through the allocate state and,
// for a tail add to a non-empty list, the link state. Get, insert and delete
// walk the list from the head, reading the node store once per link. The free
// pool starts from a counter of unused slots, so the block is ready right
// after reset with no clearing pass.
`default_nettype none

module indexed_linked_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [2:0]  in_command,
  input  wire logic        [6:0]  in_position,
  input  wire logic signed [31:0] in_item_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed      [31:0] out_read_value,
  output logic             [1:0]  out_status,
  output logic             [6:0]  out_list_length
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (LW > ille_pkg::POS_W) ? LW : ille_pkg::POS_W;
  localparam int DW   = ille_pkg::VAL_W + LW;
  localparam logic [LW-1:0] NONE = LW'(CAPACITY);

  // Control state
  ille_pkg::state_t state_r, state_nxt;
  ille_pkg::mode_t  mode_r, mode_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LW-1:0]    head_r, head_nxt;
  logic [LW-1:0]    tail_r, tail_nxt;
  logic [LW-1:0]    len_r, len_nxt;

  // Item payload and walk registers
  logic [ille_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [LW-1:0]              cur_r, cur_nxt;
  logic [CMPW-1:0]            rem_r, rem_nxt;
  logic [LW-1:0]              victim_r, victim_nxt;
  logic [IW-1:0]              new_r, new_nxt;
  logic [ille_pkg::VAL_W-1:0] res_val_r, res_val_nxt;
  logic [ille_pkg::STS_W-1:0] res_st_r, res_st_nxt;
  logic [ille_pkg::VAL_W-1:0] out_val_r, out_val_nxt;
  logic [ille_pkg::STS_W-1:0] out_st_r, out_st_nxt;
  logic [ille_pkg::POS_W-1:0] out_len_r, out_len_nxt;

  // Node store
  logic [DW-1:0]              node_mem [CAPACITY];
  logic [DW-1:0]              nd_q_r;
  logic                       nd_re;
  logic [IW-1:0]              nd_raddr;
  logic                       nd_we_full;
  logic                       nd_we_link;
  logic [IW-1:0]              nd_waddr;
  logic [LW-1:0]              nd_wlink;
  logic [ille_pkg::VAL_W-1:0] nd_q_val;
  logic [LW-1:0]              nd_q_link;

  // Free pool
  ille_pkg::pool_ctl_t pool_ctl;
  logic [IW-1:0]       alloc_slot;
  logic [IW-1:0]       push_slot;

  // Request decode
  logic                       accept;
  logic                       fin_load;
  logic [CMPW-1:0]            pos_ext;
  logic [CMPW-1:0]            len_ext;
  logic                       full;
  ille_pkg::mode_t            dec_mode;
  logic [ille_pkg::STS_W-1:0] dec_st;
  logic [CMPW-1:0]            dec_rem;

  assign nd_q_val  = nd_q_r[DW-1:LW];
  assign nd_q_link = nd_q_r[LW-1:0];
  assign pos_ext   = CMPW'(in_position);
  assign len_ext   = CMPW'(len_r);
  assign full      = (len_r == NONE);
  assign in_ready  = (state_r == ille_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign fin_load  = (state_r == ille_pkg::S_FIN) && (!out_valid_r || out_ready);

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_val_r;
  assign out_status      = out_st_r;
  assign out_list_length = out_len_r;

  ille_free_pool #(
    .CAPACITY (CAPACITY)
  ) u_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pool_ctl),
    .push_slot  (push_slot),
    .alloc_slot (alloc_slot)
  );

  // Classify the request against the current length
  always_comb begin
    dec_mode = ille_pkg::M_NONE;
    dec_st   = ille_pkg::STS_DONE;
    dec_rem  = pos_ext - CMPW'(1);
    case (in_command)
      ille_pkg::CMD_GET: begin
        dec_rem = pos_ext;
        if (pos_ext >= len_ext) begin
          dec_st = ille_pkg::STS_RANGE;
        end else begin
          dec_mode = ille_pkg::M_GET;
        end
      end
      ille_pkg::CMD_ADD_HEAD, ille_pkg::CMD_ADD_TAIL: begin
        if (full) begin
          dec_st = ille_pkg::STS_FULL;
        end else if (in_command == ille_pkg::CMD_ADD_HEAD) begin
          dec_mode = ille_pkg::M_HEAD;
        end else begin
          dec_mode = ille_pkg::M_TAIL;
        end
      end
      ille_pkg::CMD_INSERT: begin
        if (pos_ext > len_ext) begin
          dec_st = ille_pkg::STS_RANGE;
        end else if (full) begin
          dec_st = ille_pkg::STS_FULL;
        end else if (pos_ext == '0) begin
          dec_mode = ille_pkg::M_HEAD;
        end else if (pos_ext == len_ext) begin
          dec_mode = ille_pkg::M_TAIL;
        end else begin
          dec_mode = ille_pkg::M_MID;
        end
      end
      ille_pkg::CMD_DELETE: begin
        if (pos_ext >= len_ext) begin
          dec_st = ille_pkg::STS_RANGE;
        end else if (pos_ext == '0) begin
          dec_mode = ille_pkg::M_DEL0;
        end else begin
          dec_mode = ille_pkg::M_DELM;
        end
      end
      default: begin
        dec_mode = ille_pkg::M_NONE;
      end
    endcase
  end

  // Next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ille_pkg::S_IDLE: begin
        if (accept) begin
          case (dec_mode)
            ille_pkg::M_GET, ille_pkg::M_MID, ille_pkg::M_DELM:
              state_nxt = ille_pkg::S_WALK;
            ille_pkg::M_DEL0:
              state_nxt = ille_pkg::S_DEL_NEXT;
            ille_pkg::M_HEAD, ille_pkg::M_TAIL:
              state_nxt = ille_pkg::S_ALLOC;
            default:
              state_nxt = ille_pkg::S_FIN;
          endcase
        end
      end
      ille_pkg::S_WALK: begin
        if (rem_r == '0) begin
          case (mode_r)
            ille_pkg::M_MID:  state_nxt = ille_pkg::S_ALLOC;
            ille_pkg::M_DELM: state_nxt = ille_pkg::S_DEL_NEXT;
            default:          state_nxt = ille_pkg::S_FIN;
          endcase
        end
      end
      ille_pkg::S_DEL_NEXT: begin
        state_nxt = ille_pkg::S_FIN;
      end
      ille_pkg::S_ALLOC: begin
        if (mode_r == ille_pkg::M_MID ||
            (mode_r == ille_pkg::M_TAIL && tail_r != NONE)) begin
          state_nxt = ille_pkg::S_LINK;
        end else begin
          state_nxt = ille_pkg::S_FIN;
        end
      end
      ille_pkg::S_LINK: begin
        state_nxt = ille_pkg::S_FIN;
      end
      ille_pkg::S_FIN: begin
        if (fin_load) begin
          state_nxt = ille_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ille_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, node store accesses and pool controls per state
  always_comb begin
    mode_nxt      = mode_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    victim_nxt    = victim_r;
    new_nxt       = new_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_len_nxt   = out_len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    nd_re         = 1'b0;
    nd_raddr      = head_r[IW-1:0];
    nd_we_full    = 1'b0;
    nd_we_link    = 1'b0;
    nd_waddr      = cur_r[IW-1:0];
    nd_wlink      = NONE;
    pool_ctl      = '0;
    push_slot     = victim_r[IW-1:0];

    case (state_r)
      // Latch the item, start the walk at the head, prefetch a free slot for an add
      ille_pkg::S_IDLE: begin
        if (accept) begin
          mode_nxt    = dec_mode;
          val_nxt     = in_item_value;
          res_val_nxt = ille_pkg::NO_VALUE;
          res_st_nxt  = dec_st;
          cur_nxt     = head_r;
          victim_nxt  = head_r;
          rem_nxt     = dec_rem;
          if (dec_mode == ille_pkg::M_GET || dec_mode == ille_pkg::M_MID ||
              dec_mode == ille_pkg::M_DELM || dec_mode == ille_pkg::M_DEL0) begin
            nd_re = 1'b1;
          end
          if (dec_mode == ille_pkg::M_HEAD || dec_mode == ille_pkg::M_TAIL ||
              dec_mode == ille_pkg::M_MID) begin
            pool_ctl.prefetch = 1'b1;
          end
        end
      end
      // Follow one link per cycle until the target node is in the read register
      ille_pkg::S_WALK: begin
        if (rem_r != '0) begin
          nd_re    = 1'b1;
          nd_raddr = nd_q_link[IW-1:0];
          cur_nxt  = nd_q_link;
          rem_nxt  = rem_r - CMPW'(1);
        end else if (mode_r == ille_pkg::M_GET) begin
          res_val_nxt = nd_q_val;
        end else if (mode_r == ille_pkg::M_DELM) begin
          victim_nxt = nd_q_link;
          nd_re      = 1'b1;
          nd_raddr   = nd_q_link[IW-1:0];
        end
      end
      // Unlink the victim and return its slot
      ille_pkg::S_DEL_NEXT: begin
        pool_ctl.push = 1'b1;
        len_nxt       = len_r - LW'(1);
        if (mode_r == ille_pkg::M_DEL0) begin
          head_nxt = nd_q_link;
          if (nd_q_link == NONE) begin
            tail_nxt = NONE;
          end
        end else begin
          nd_we_link = 1'b1;
          nd_waddr   = cur_r[IW-1:0];
          nd_wlink   = nd_q_link;
          if (victim_r == tail_r) begin
            tail_nxt = cur_r;
          end
        end
      end
      // Fill the new node
      ille_pkg::S_ALLOC: begin
        pool_ctl.pop = 1'b1;
        len_nxt      = len_r + LW'(1);
        nd_we_full   = 1'b1;
        nd_waddr     = alloc_slot;
        new_nxt      = alloc_slot;
        case (mode_r)
          ille_pkg::M_HEAD: begin
            nd_wlink = head_r;
            head_nxt = LW'(alloc_slot);
            if (tail_r == NONE) begin
              tail_nxt = LW'(alloc_slot);
            end
          end
          ille_pkg::M_TAIL: begin
            nd_wlink = NONE;
            tail_nxt = LW'(alloc_slot);
            cur_nxt  = tail_r;
            if (tail_r == NONE) begin
              head_nxt = LW'(alloc_slot);
            end
          end
          default: begin
            nd_wlink = nd_q_link;
          end
        endcase
      end
      // Point the predecessor at the new node
      ille_pkg::S_LINK: begin
        nd_we_link = 1'b1;
        nd_waddr   = cur_r[IW-1:0];
        nd_wlink   = LW'(new_r);
      end
      // Hand the result to the output register
      ille_pkg::S_FIN: begin
        if (fin_load) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          out_len_nxt   = len_ext[ille_pkg::POS_W-1:0];
        end
      end
      default: begin
        mode_nxt = ille_pkg::M_NONE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ille_pkg::S_IDLE;
      mode_r      <= ille_pkg::M_NONE;
      out_valid_r <= 1'b0;
      head_r      <= NONE;
      tail_r      <= NONE;
      len_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    cur_r     <= cur_nxt;
    rem_r     <= rem_nxt;
    victim_r  <= victim_nxt;
    new_r     <= new_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
    out_len_r <= out_len_nxt;
  end

  // Node store: full-entry or link-only write, registered read
  always_ff @(posedge clk) begin
    if (nd_we_full) begin
      node_mem[nd_waddr] <= {val_r, nd_wlink};
    end else if (nd_we_link) begin
      node_mem[nd_waddr][LW-1:0] <= nd_wlink;
    end
    if (nd_re) begin
      nd_q_r <= node_mem[nd_raddr];
    end
  end

  // Length never exceeds the store
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= NONE)
    else $error("list length beyond capacity");

  // Empty list has no head and no tail
  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) == (head_r == NONE))
    else $error("head slot disagrees with list length");

  a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) == (tail_r == NONE))
    else $error("tail slot disagrees with list length");

  // An accepted item leaves the idle state
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ille_pkg::S_IDLE))
    else $error("accepted item did not start");

  // Walk reads never use the empty-link code
  a_walk_link: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ille_pkg::S_WALK && rem_r != '0) |-> (nd_q_link != NONE))
    else $error("walk ran off the end of the list");

endmodule

`default_nettype wire

[hdl/ille_free_pool.sv]
// ----------------------------------------------------------------------------
// ille_free_pool
// Free-slot allocator: a stack memory of returned slots plus a counter of
// slots never handed out, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ille_free_pool #(
  parameter int CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ille_pkg::pool_ctl_t         ctl,
  input  wire logic [$clog2(CAPACITY)-1:0] push_slot,
  output logic      [$clog2(CAPACITY)-1:0] alloc_slot
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] stk_mem [CAPACITY];
  logic [IW-1:0] top_q_r;
  logic [CW-1:0] stk_cnt_r, stk_cnt_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic [CW-1:0] top_idx;
  logic          stk_empty;

  assign stk_empty  = (stk_cnt_r == '0);
  assign top_idx    = stk_cnt_r - CW'(1);
  assign alloc_slot = stk_empty ? fresh_r[IW-1:0] : top_q_r;

  // Advance the stack depth and the fresh-slot counter
  always_comb begin
    stk_cnt_nxt = stk_cnt_r;
    fresh_nxt   = fresh_r;
    if (ctl.pop) begin
      if (stk_empty) begin
        fresh_nxt = fresh_r + CW'(1);
      end else begin
        stk_cnt_nxt = stk_cnt_r - CW'(1);
      end
    end else if (ctl.push) begin
      stk_cnt_nxt = stk_cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_cnt_r <= '0;
      fresh_r   <= '0;
    end else begin
      stk_cnt_r <= stk_cnt_nxt;
      fresh_r   <= fresh_nxt;
    end
  end

  // Stack memory: push at the top, read the top on a prefetch ahead of a pop
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stk_mem[stk_cnt_r[IW-1:0]] <= push_slot;
    end
    if (ctl.prefetch) begin
      top_q_r <= stk_mem[top_idx[IW-1:0]];
    end
  end

  // Returned slots never outnumber slots handed out
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cnt_r <= fresh_r)
    else $error("free stack holds more slots than were handed out");

  // A fresh slot is only taken while one is left
  a_fresh_left: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop && stk_empty) |-> (fresh_r < CW'(CAPACITY)))
    else $error("pop with no free slot");

  // Push never meets a pop or a prefetch in one cycle
  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && (ctl.pop || ctl.prefetch)))
    else $error("free pool push overlaps a pop");

endmodule

`default_nettype wire
